// File: src/imuw_pkg.sv
`timescale 1ns / 1ps
// imuw_pkg: shared types and constants for the IMU sample health watchdog.
// No dependencies; used by the lane, health and top-level modules.
package imuw_pkg;

    // Input item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REINIT = 1'b1;

    // Fault reason codes
    localparam logic [2:0] RS_NONE      = 3'd0;
    localparam logic [2:0] RS_NONFINITE = 3'd1;
    localparam logic [2:0] RS_ZERO      = 3'd2;
    localparam logic [2:0] RS_FLAT      = 3'd3;
    localparam logic [2:0] RS_DEGEN     = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_CNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CNT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_CNT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGEN_CNT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REINIT_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MS    = 3'd7;

    // Widths
    localparam int LANES        = 6;
    localparam int CNT_W        = 16;
    localparam int TOL_W        = 31;
    localparam int TIME_W       = 64;
    localparam int TOTAL_W      = 32;
    localparam int BACKOFF_NS_W = 36;   // 65535 ms in ns fits in 36 bits
    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    // Reset values of the configuration registers
    localparam logic              RST_WATCH_ENABLE = 1'b1;
    localparam logic [CNT_W-1:0]  RST_RECOVERY_CNT = 16'd10;
    localparam logic [CNT_W-1:0]  RST_ZERO_CNT     = 16'd3;
    localparam logic [CNT_W-1:0]  RST_FLAT_CNT     = 16'd50;
    localparam logic [CNT_W-1:0]  RST_DEGEN_CNT    = 16'd3;
    localparam logic [TOL_W-1:0]  RST_TOLERANCE    = 31'd66;
    localparam logic [CNT_W-1:0]  RST_REINIT_LIMIT = 16'd5;
    localparam logic [BACKOFF_NS_W-1:0] RST_BACKOFF_NS = 36'd1000000000;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic                    watch_enable;
        logic [CNT_W-1:0]        recovery_cnt;
        logic [CNT_W-1:0]        zero_cnt;
        logic [CNT_W-1:0]        flat_cnt;
        logic [CNT_W-1:0]        degen_cnt;
        logic [TOL_W-1:0]        tolerance;
        logic [CNT_W-1:0]        reinit_limit;
        logic [BACKOFF_NS_W-1:0] backoff_ns;
    } t_cfg;

    // What one lane finds about its axis
    typedef struct packed {
        logic is_zero;      // axis value is exactly zero
        logic near_prev;    // within tolerance of the previous sample
        logic near_next;    // within tolerance of the next axis of its group
    } t_lane_flags;

    // One result beat
    typedef struct packed {
        logic [1:0]         health_state;
        logic [2:0]         fault_reason;
        logic               sample_invalid;
        logic               fault_onset;
        logic               reinit_request;
        logic [TOTAL_W-1:0] fault_total;
        logic [2:0]         last_reason;
    } t_result;

endpackage

// File: src/imuw_in_if.sv
`timescale 1ns / 1ps
// imuw_in_if: valid/ready channel carrying one IMU sample or reinit report.
// No dependencies.
interface imuw_in_if #(
    parameter int AXIS_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [AXIS_BITS-1:0] accel_x;
    logic [AXIS_BITS-1:0] accel_y;
    logic [AXIS_BITS-1:0] accel_z;
    logic [AXIS_BITS-1:0] gyro_x;
    logic [AXIS_BITS-1:0] gyro_y;
    logic [AXIS_BITS-1:0] gyro_z;
    logic                 value_bad;
    logic [63:0]          now_time;
    logic                 reinit_ok;

    modport source (
        output valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
               value_bad, now_time, reinit_ok,
        input  ready
    );
    modport sink (
        input  valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
               value_bad, now_time, reinit_ok,
        output ready
    );
endinterface

// File: src/imuw_out_if.sv
`timescale 1ns / 1ps
// imuw_out_if: valid/ready channel carrying one watchdog result.
// No dependencies.
interface imuw_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  health_state;
    logic [2:0]  fault_reason;
    logic        sample_invalid;
    logic        fault_onset;
    logic        reinit_request;
    logic [31:0] fault_total;
    logic [2:0]  last_reason;

    modport source (
        output valid, health_state, fault_reason, sample_invalid, fault_onset,
               reinit_request, fault_total, last_reason,
        input  ready
    );
    modport sink (
        input  valid, health_state, fault_reason, sample_invalid, fault_onset,
               reinit_request, fault_total, last_reason,
        output ready
    );
endinterface

// File: src/imuw_lane.sv
`timescale 1ns / 1ps
// imuw_lane: one axis lane; holds the previous value and does the zero,
// flatline and neighbor-equality compares. Depends on imuw_pkg.
module imuw_lane import imuw_pkg::*; #(
    parameter int AXIS_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_store,
    input  logic [AXIS_BITS-1:0] i_axis,
    input  logic [AXIS_BITS-1:0] i_neighbor,
    input  logic [TOL_W-1:0]     i_tolerance,
    output t_lane_flags          o_flags
);

    localparam int CMP_W = (AXIS_BITS > TOL_W) ? AXIS_BITS : TOL_W;
    localparam logic [AXIS_BITS-1:0] SIGN_BIT = {1'b1, {(AXIS_BITS-1){1'b0}}};

    logic [AXIS_BITS-1:0] r_prev;

    // |a - b| <= tol, on offset-binary keys so unsigned order is signed order
    function automatic logic near(input logic [AXIS_BITS-1:0] a,
                                  input logic [AXIS_BITS-1:0] b,
                                  input logic [TOL_W-1:0]     tol);
        logic [AXIS_BITS:0]   diff;
        logic [AXIS_BITS-1:0] mag;
        diff = {1'b0, a ^ SIGN_BIT} - {1'b0, b ^ SIGN_BIT};
        mag  = diff[AXIS_BITS] ? AXIS_BITS'(-diff) : diff[AXIS_BITS-1:0];
        return CMP_W'(mag) <= CMP_W'(tol);
    endfunction

    // previous sample, updated on every accepted sensor beat
    always_ff @(posedge i_clk) begin
        if (i_store) begin
            r_prev <= i_axis;
        end
    end

    always_comb begin
        o_flags.is_zero   = (i_axis == '0);
        o_flags.near_prev = near(i_axis, r_prev, i_tolerance);
        o_flags.near_next = near(i_axis, i_neighbor, i_tolerance);
    end

endmodule

// File: src/imuw_health.sv
`timescale 1ns / 1ps
// imuw_health: merges the lane flags into a classification and runs the
// health state machine, streak counters and reinit scheduling. Depends on imuw_pkg.
module imuw_health import imuw_pkg::*; #(
    parameter int RUN_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_kind,
    input  logic                    i_value_bad,
    input  logic [TIME_W-1:0]       i_now_time,
    input  logic                    i_reinit_ok,
    input  t_cfg                    i_cfg,
    input  t_lane_flags [LANES-1:0] i_lanes,
    output t_result                 o_result
);

    localparam int RCMP_W = (RUN_BITS > CNT_W) ? RUN_BITS : CNT_W;

    typedef enum logic [1:0] {
        HEALTHY    = 2'd0,
        SUSPECT    = 2'd1,
        FAULTED    = 2'd2,
        RECOVERING = 2'd3
    } t_mode;

    t_mode               r_mode,        n_mode;
    logic                r_prev_valid,  n_prev_valid;
    logic [RUN_BITS-1:0] r_zero_run,    n_zero_run;
    logic [RUN_BITS-1:0] r_flat_run,    n_flat_run;
    logic [RUN_BITS-1:0] r_degen_run,   n_degen_run;
    logic [RUN_BITS-1:0] r_healthy_run, n_healthy_run;
    logic [RUN_BITS-1:0] r_tries,       n_tries;
    logic [TIME_W-1:0]   r_next_time,   n_next_time;
    logic [TOTAL_W-1:0]  r_entries,     n_entries;
    logic [2:0]          r_latest,      n_latest;

    function automatic logic [RUN_BITS-1:0] run_inc(input logic [RUN_BITS-1:0] r);
        return (r == '1) ? r : r + 1'b1;
    endfunction

    // merge of the lane flags
    logic [LANES-1:0] zero_vec;
    logic [LANES-1:0] prev_vec;
    logic             all_zero;
    logic             degen;
    logic             flat;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            zero_vec[i] = i_lanes[i].is_zero;
            prev_vec[i] = i_lanes[i].near_prev;
        end
        all_zero = &zero_vec;
        // accel x~y~z chained, gyro x~y~z chained
        degen    = i_lanes[0].near_next & i_lanes[1].near_next &
                   i_lanes[3].near_next & i_lanes[4].near_next;
        flat     = r_prev_valid & (&prev_vec);
    end

    // next state and result
    logic [2:0]          reason;
    logic                invalid;
    logic                entered;
    logic                request;
    logic                do_fault;
    logic                fault_or_recov;
    logic [RUN_BITS-1:0] bumped;
    logic [CNT_W-1:0]    limit;
    logic [RUN_BITS-1:0] good_run;

    always_comb begin
        n_mode        = r_mode;
        n_prev_valid  = r_prev_valid;
        n_zero_run    = r_zero_run;
        n_flat_run    = r_flat_run;
        n_degen_run   = r_degen_run;
        n_healthy_run = r_healthy_run;
        n_tries       = r_tries;
        n_next_time   = r_next_time;
        n_entries     = r_entries;
        n_latest      = r_latest;
        reason        = RS_NONE;
        invalid       = 1'b0;
        entered       = 1'b0;
        request       = 1'b0;
        do_fault      = 1'b0;
        bumped        = '0;
        limit         = '0;
        good_run      = '0;
        fault_or_recov = 1'b0;

        if (i_kind == KIND_REINIT) begin
            // reinit report: count attempt, arm backoff, pick new state
            if (i_cfg.watch_enable) begin
                n_tries     = run_inc(r_tries);
                n_next_time = i_now_time + TIME_W'(i_cfg.backoff_ns);
                n_mode      = i_reinit_ok ? RECOVERING : FAULTED;
            end
        end else if (!i_cfg.watch_enable) begin
            n_prev_valid = !i_value_bad;
        end else begin
            // classify by priority
            if (i_value_bad) begin
                reason = RS_NONFINITE;
            end else if (all_zero) begin
                reason = RS_ZERO;
            end else if (degen) begin
                reason = RS_DEGEN;
            end else if (flat) begin
                reason = RS_FLAT;
            end

            if (reason == RS_NONE) begin
                n_zero_run  = '0;
                n_flat_run  = '0;
                n_degen_run = '0;
                if (r_mode == FAULTED || r_mode == RECOVERING) begin
                    good_run = run_inc(r_healthy_run);
                    invalid  = 1'b1;
                    if (RCMP_W'(good_run) >= RCMP_W'(i_cfg.recovery_cnt)) begin
                        n_mode        = HEALTHY;
                        n_healthy_run = '0;
                        n_tries       = '0;
                        invalid       = 1'b0;
                    end else begin
                        n_mode        = RECOVERING;
                        n_healthy_run = good_run;
                    end
                end else begin
                    n_mode        = HEALTHY;
                    n_healthy_run = '0;
                end
            end else begin
                n_healthy_run = '0;
                case (reason)
                    RS_ZERO: begin
                        bumped     = run_inc(r_zero_run);
                        limit      = i_cfg.zero_cnt;
                        n_zero_run = bumped;
                        do_fault   = RCMP_W'(bumped) >= RCMP_W'(limit);
                    end
                    RS_FLAT: begin
                        bumped     = run_inc(r_flat_run);
                        limit      = i_cfg.flat_cnt;
                        n_flat_run = bumped;
                        do_fault   = RCMP_W'(bumped) >= RCMP_W'(limit);
                    end
                    RS_DEGEN: begin
                        bumped      = run_inc(r_degen_run);
                        limit       = i_cfg.degen_cnt;
                        n_degen_run = bumped;
                        do_fault    = RCMP_W'(bumped) >= RCMP_W'(limit);
                    end
                    default: begin
                        // non-finite faults at once
                        do_fault = 1'b1;
                    end
                endcase

                if (do_fault) begin
                    n_mode        = FAULTED;
                    n_latest      = reason;
                    n_next_time   = i_now_time;
                    n_entries     = (r_entries == '1) ? r_entries : r_entries + 1'b1;
                    n_zero_run    = '0;
                    n_flat_run    = '0;
                    n_degen_run   = '0;
                    n_healthy_run = '0;
                    entered       = 1'b1;
                end else if (r_mode == HEALTHY) begin
                    n_mode = SUSPECT;
                end
                invalid = (n_mode == FAULTED || n_mode == RECOVERING);
            end

            // reinit request: bad state, attempts left, backoff expired or fault just entered
            fault_or_recov = (n_mode == FAULTED || n_mode == RECOVERING);
            request = fault_or_recov &&
                      (i_cfg.reinit_limit == '0 ||
                       RCMP_W'(n_tries) < RCMP_W'(i_cfg.reinit_limit)) &&
                      (entered || i_now_time >= r_next_time);
            n_prev_valid = !i_value_bad;
        end

        o_result.health_state   = n_mode;
        o_result.fault_reason   = reason;
        o_result.sample_invalid = invalid;
        o_result.fault_onset    = entered;
        o_result.reinit_request = request;
        o_result.fault_total    = n_entries;
        o_result.last_reason    = n_latest;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= HEALTHY;
            r_prev_valid  <= 1'b0;
            r_zero_run    <= '0;
            r_flat_run    <= '0;
            r_degen_run   <= '0;
            r_healthy_run <= '0;
            r_tries       <= '0;
            r_next_time   <= '0;
            r_entries     <= '0;
            r_latest      <= RS_NONE;
        end else if (i_accept) begin
            r_mode        <= n_mode;
            r_prev_valid  <= n_prev_valid;
            r_zero_run    <= n_zero_run;
            r_flat_run    <= n_flat_run;
            r_degen_run   <= n_degen_run;
            r_healthy_run <= n_healthy_run;
            r_tries       <= n_tries;
            r_next_time   <= n_next_time;
            r_entries     <= n_entries;
            r_latest      <= n_latest;
        end
    end

endmodule

// File: src/imu_sample_health_watchdog.sv
`timescale 1ns / 1ps
// IMU sample health watchdog top level; uses imuw_pkg, the channel interfaces,
// imuw_lane and imuw_health. An accepted beat's result is registered and offered in the
// cycle after. Throughput: 1 beat per cycle; lanes and health update are combinational, and a
// new beat enters in the cycle the held result is taken (a stalled result holds it off).
// Reset (synchronous, active low) clears health state, counters and output valid,
// and loads the configuration defaults.
module imu_sample_health_watchdog import imuw_pkg::*; #(
    parameter int AXIS_BITS = 32,
    parameter int RUN_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    imuw_in_if.sink               i_sample,
    imuw_out_if.source            o_result
);

    // configuration registers
    t_cfg r_cfg, n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        unique case (i_cfg_index)
            CFG_WATCH_ENABLE: n_cfg.watch_enable = i_cfg_data[0];
            CFG_RECOVERY_CNT: n_cfg.recovery_cnt = i_cfg_data[CNT_W-1:0];
            CFG_ZERO_CNT:     n_cfg.zero_cnt     = i_cfg_data[CNT_W-1:0];
            CFG_FLAT_CNT:     n_cfg.flat_cnt     = i_cfg_data[CNT_W-1:0];
            CFG_DEGEN_CNT:    n_cfg.degen_cnt    = i_cfg_data[CNT_W-1:0];
            CFG_TOLERANCE:    n_cfg.tolerance    = i_cfg_data[TOL_W-1:0];
            CFG_REINIT_LIMIT: n_cfg.reinit_limit = i_cfg_data[CNT_W-1:0];
            // backoff kept in ns so the item path only adds
            CFG_BACKOFF_MS:   n_cfg.backoff_ns   =
                BACKOFF_NS_W'(i_cfg_data[CNT_W-1:0]) * BACKOFF_NS_W'(NS_PER_MS);
            default:          n_cfg = r_cfg;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.watch_enable <= RST_WATCH_ENABLE;
            r_cfg.recovery_cnt <= RST_RECOVERY_CNT;
            r_cfg.zero_cnt     <= RST_ZERO_CNT;
            r_cfg.flat_cnt     <= RST_FLAT_CNT;
            r_cfg.degen_cnt    <= RST_DEGEN_CNT;
            r_cfg.tolerance    <= RST_TOLERANCE;
            r_cfg.reinit_limit <= RST_REINIT_LIMIT;
            r_cfg.backoff_ns   <= RST_BACKOFF_NS;
        end else if (i_cfg_we) begin
            r_cfg <= n_cfg;
        end
    end

    // handshake: output register frees itself when its beat is taken
    logic    r_out_valid;
    t_result r_result;
    t_result n_result;
    logic    accept;

    assign i_sample.ready = !r_out_valid || o_result.ready;
    assign accept         = i_sample.valid && i_sample.ready;

    // axis lanes
    logic [AXIS_BITS-1:0]    axis [LANES];
    t_lane_flags [LANES-1:0] lane_flags;
    logic                    store_prev;

    assign axis[0]    = i_sample.accel_x;
    assign axis[1]    = i_sample.accel_y;
    assign axis[2]    = i_sample.accel_z;
    assign axis[3]    = i_sample.gyro_x;
    assign axis[4]    = i_sample.gyro_y;
    assign axis[5]    = i_sample.gyro_z;
    assign store_prev = accept && (i_sample.kind == KIND_SAMPLE);

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        // last axis of each group of three compares with itself (unused)
        localparam int NB = ((g % 3) == 2) ? g : g + 1;
        imuw_lane #(
            .AXIS_BITS (AXIS_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_store     (store_prev),
            .i_axis      (axis[g]),
            .i_neighbor  (axis[NB]),
            .i_tolerance (r_cfg.tolerance),
            .o_flags     (lane_flags[g])
        );
    end

    // merge and health state machine
    imuw_health #(
        .RUN_BITS (RUN_BITS)
    ) u_health (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_kind      (i_sample.kind),
        .i_value_bad (i_sample.value_bad),
        .i_now_time  (i_sample.now_time),
        .i_reinit_ok (i_sample.reinit_ok),
        .i_cfg       (r_cfg),
        .i_lanes     (lane_flags),
        .o_result    (n_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.health_state   = r_result.health_state;
    assign o_result.fault_reason   = r_result.fault_reason;
    assign o_result.sample_invalid = r_result.sample_invalid;
    assign o_result.fault_onset    = r_result.fault_onset;
    assign o_result.reinit_request = r_result.reinit_request;
    assign o_result.fault_total    = r_result.fault_total;
    assign o_result.last_reason    = r_result.last_reason;

endmodule
